// ----- design/assert_macros.svh -----
// assertion helpers included by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/ssal_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssal_pkg
// Shared types, constants and helpers of the stream slot admission limiter.
// ---------------------------------------------------------------------------
package ssal_pkg;

   localparam int SLOTS = 8;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int OCC_W = $clog2(SLOTS + 1);

   localparam logic [47:0] PENDING_LIMIT_MS = 48'd30000;
   localparam logic [11:0] MAX_SECONDS      = 12'd3600;
   localparam logic [21:0] MS_PER_SECOND    = 22'd1000;

   // request kinds
   typedef enum logic [1:0] {
      KIND_CHECK   = 2'd0,
      KIND_SUCCESS = 2'd1,
      KIND_FAILURE = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RATE    = 2'd1,
      STATUS_NO_SLOT = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic [2:0] CSR_ENABLE        = 3'd0;
   localparam logic [2:0] CSR_MAX_REQUESTS  = 3'd1;
   localparam logic [2:0] CSR_WINDOW_SEC    = 3'd2;
   localparam logic [2:0] CSR_IDLE_SEC      = 3'd3;
   localparam logic [2:0] CSR_MAX_SLOTS     = 3'd4;
   localparam logic [2:0] CSR_SWITCH_SEC    = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [47:0] now_ms;
      logic [31:0] client_id;
      logic [15:0] service_id;
      logic [15:0] program_id;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [21:0] wait_ms;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WINDOW,
      ST_PURGE,
      ST_FIND,
      ST_APPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic window;
      logic purge;
      logic find;
      logic apply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
   } stat_type;

   // seconds to milliseconds, zero means one second, clamped to an hour
   function automatic logic [21:0] span_ms(input logic [11:0] seconds);
      logic [21:0] r;
      if (seconds == 12'd0) begin
         r = MS_PER_SECOND;
      end else if (seconds > MAX_SECONDS) begin
         r = 22'(MAX_SECONDS) * MS_PER_SECOND;
      end else begin
         r = 22'(seconds) * MS_PER_SECOND;
      end
      return r;
   endfunction

endpackage

// ----- design/ssal_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssal_ctrl
// Sequencer: window restart, purge, search, then apply and post the result.
// ---------------------------------------------------------------------------
module ssal_ctrl import ssal_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            cmd.window = 1'b1;
            state_in   = ST_PURGE;
         end
         ST_PURGE: begin
            cmd.purge = 1'b1;
            state_in  = ST_FIND;
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (!stat.out_busy) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- design/ssal_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssal_datapath
// Slot table, request window, configuration and result register.
// ---------------------------------------------------------------------------
module ssal_datapath import ssal_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  req_item_type req_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   // configuration
   logic        enable_ff;
   logic [15:0] max_req_ff;
   logic [11:0] win_sec_ff, idle_sec_ff, sw_sec_ff;
   logic [6:0]  max_slots_ff;
   logic [21:0] win_span_ff, idle_span_ff, sw_delay_ff;

   // item and slot table
   req_item_type item_ff;
   logic [31:0] client_ff [SLOTS];
   logic [15:0] service_ff [SLOTS];
   logic [15:0] program_ff [SLOTS];
   logic        pending_ff [SLOTS];
   logic [47:0] since_ff [SLOTS];
   logic [47:0] last_ff [SLOTS];
   logic [31:0] client_in [SLOTS];
   logic [15:0] service_in [SLOTS];
   logic [15:0] program_in [SLOTS];
   logic        pending_in [SLOTS];
   logic [47:0] since_in [SLOTS];
   logic [47:0] last_in [SLOTS];
   logic [47:0] window_ff, window_in;
   logic [15:0] count_ff, count_in;

   // search results
   logic             exact_hit_ff, old_hit_ff, free_hit_ff;
   logic [IDX_W-1:0] exact_idx_ff, old_idx_ff, free_idx_ff;
   logic [OCC_W-1:0] occ_ff;
   logic             exact_hit_in, old_hit_in, free_hit_in;
   logic [IDX_W-1:0] exact_idx_in, old_idx_in, free_idx_in;
   logic [OCC_W-1:0] occ_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic        kind_timed;
   logic [48:0] win_age;

   assign kind_timed = enable_ff && (item_ff.req_type == KIND_CHECK ||
                                     item_ff.req_type == KIND_SUCCESS);
   assign win_age    = {1'b0, item_ff.now_ms} - {1'b0, window_ff};

   // configuration registers and derived spans
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         max_req_ff   <= '0;
         win_sec_ff   <= '0;
         idle_sec_ff  <= '0;
         max_slots_ff <= 7'd1;
         sw_sec_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:       enable_ff    <= csr_data[0];
            CSR_MAX_REQUESTS: max_req_ff   <= csr_data;
            CSR_WINDOW_SEC:   win_sec_ff   <= csr_data[11:0];
            CSR_IDLE_SEC:     idle_sec_ff  <= csr_data[11:0];
            CSR_MAX_SLOTS:    max_slots_ff <= csr_data[6:0];
            CSR_SWITCH_SEC:   sw_sec_ff    <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      win_span_ff  <= span_ms(win_sec_ff);
      idle_span_ff <= span_ms(idle_sec_ff);
      sw_delay_ff  <= 22'(sw_sec_ff) * MS_PER_SECOND;
   end

   // search over the table after purge
   always_comb begin
      exact_hit_in = 1'b0;
      old_hit_in   = 1'b0;
      free_hit_in  = 1'b0;
      exact_idx_in = '0;
      old_idx_in   = '0;
      free_idx_in  = '0;
      occ_in       = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (client_ff[i] == item_ff.client_id && service_ff[i] == item_ff.service_id &&
             program_ff[i] == item_ff.program_id) begin
            exact_hit_in = 1'b1;
            exact_idx_in = IDX_W'(i);
         end
         if (client_ff[i] == item_ff.client_id) begin
            old_hit_in = 1'b1;
            old_idx_in = IDX_W'(i);
         end
         if (client_ff[i] == 32'd0) begin
            free_hit_in = 1'b1;
            free_idx_in = IDX_W'(i);
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         occ_in = occ_in + OCC_W'(client_ff[i] != 32'd0);
      end
   end

   // table, window and result updates
   always_comb begin
      logic [48:0]      age;
      logic [6:0]       limit;
      logic             full, use_old, tgt_hit, switching;
      logic [IDX_W-1:0] tgt;
      for (int i = 0; i < SLOTS; i++) begin
         client_in[i]  = client_ff[i];
         service_in[i] = service_ff[i];
         program_in[i] = program_ff[i];
         pending_in[i] = pending_ff[i];
         since_in[i]   = since_ff[i];
         last_in[i]    = last_ff[i];
      end
      window_in    = window_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      limit     = (max_slots_ff == 7'd0) ? 7'd1 : max_slots_ff;
      full      = 7'(occ_ff) >= limit;
      use_old   = old_hit_ff && full;
      // a full table only admits a client that already holds a slot
      tgt_hit   = use_old || (!full && free_hit_ff);
      tgt       = use_old ? old_idx_ff : free_idx_ff;
      switching = old_hit_ff && (service_ff[old_idx_ff] != item_ff.service_id ||
                                 program_ff[old_idx_ff] != item_ff.program_id);
      age       = '0;

      // window restart
      if (cmd.window && kind_timed) begin
         if (window_ff == 48'd0 || (!win_age[48] && win_age[47:0] >= 48'(win_span_ff))) begin
            window_in = item_ff.now_ms;
            count_in  = '0;
         end
      end

      // purge stale pending and idle active slots
      if (cmd.purge && kind_timed) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (client_ff[i] != 32'd0) begin
               if (pending_ff[i]) begin
                  age = {1'b0, item_ff.now_ms} - {1'b0, since_ff[i]};
                  if (since_ff[i] != 48'd0 && !age[48] && age[47:0] > PENDING_LIMIT_MS) begin
                     client_in[i] = '0; service_in[i] = '0; program_in[i] = '0;
                     pending_in[i] = 1'b0; since_in[i] = '0; last_in[i] = '0;
                  end
               end else begin
                  age = {1'b0, item_ff.now_ms} - {1'b0, last_ff[i]};
                  if (last_ff[i] != 48'd0 && !age[48] && age[47:0] >= 48'(idle_span_ff)) begin
                     client_in[i] = '0; service_in[i] = '0; program_in[i] = '0;
                     pending_in[i] = 1'b0; since_in[i] = '0; last_in[i] = '0;
                  end
               end
            end
         end
      end

      // decision and result
      if (cmd.apply) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.status  = STATUS_OK;
         rsp_data_in.wait_ms = '0;
         case (item_ff.req_type)
            KIND_CHECK: begin
               if (enable_ff) begin
                  if (max_req_ff != 16'd0 && count_ff >= max_req_ff) begin
                     rsp_data_in.status = STATUS_RATE;
                  end else if (exact_hit_ff) begin
                     if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
                  end else if (!tgt_hit) begin
                     rsp_data_in.status = STATUS_NO_SLOT;
                  end else begin
                     client_in[tgt]  = item_ff.client_id;
                     service_in[tgt] = item_ff.service_id;
                     program_in[tgt] = item_ff.program_id;
                     pending_in[tgt] = 1'b1;
                     since_in[tgt]   = item_ff.now_ms;
                     last_in[tgt]    = '0;
                     if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
                     if (switching) rsp_data_in.wait_ms = sw_delay_ff;
                  end
               end
            end
            KIND_SUCCESS: begin
               if (enable_ff && exact_hit_ff) begin
                  pending_in[exact_idx_ff] = 1'b0;
                  since_in[exact_idx_ff]   = '0;
                  last_in[exact_idx_ff]    = item_ff.now_ms;
               end
            end
            KIND_FAILURE: begin
               if (enable_ff && exact_hit_ff && pending_ff[exact_idx_ff]) begin
                  client_in[exact_idx_ff]  = '0;
                  service_in[exact_idx_ff] = '0;
                  program_in[exact_idx_ff] = '0;
                  pending_in[exact_idx_ff] = 1'b0;
                  since_in[exact_idx_ff]   = '0;
                  last_in[exact_idx_ff]    = '0;
               end
            end
            default: begin
               if (item_ff.client_id != 32'd0) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (client_ff[i] == item_ff.client_id) begin
                        client_in[i] = '0; service_in[i] = '0; program_in[i] = '0;
                        pending_in[i] = 1'b0; since_in[i] = '0; last_in[i] = '0;
                     end
                  end
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            client_ff[i]  <= '0;
            service_ff[i] <= '0;
            program_ff[i] <= '0;
            pending_ff[i] <= 1'b0;
            since_ff[i]   <= '0;
            last_ff[i]    <= '0;
         end
         window_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            client_ff[i]  <= client_in[i];
            service_ff[i] <= service_in[i];
            program_ff[i] <= program_in[i];
            pending_ff[i] <= pending_in[i];
            since_ff[i]   <= since_in[i];
            last_ff[i]    <= last_in[i];
         end
         window_ff    <= window_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.find) begin
         exact_hit_ff <= exact_hit_in;
         exact_idx_ff <= exact_idx_in;
         old_hit_ff   <= old_hit_in;
         old_idx_ff   <= old_idx_in;
         free_hit_ff  <= free_hit_in;
         free_idx_ff  <= free_idx_in;
         occ_ff       <= occ_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

// ----- design/stream_slot_admission_limiter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream_slot_admission_limiter
// Per-account stream slot table with a windowed request limit.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         req_valid/req_stall req_data (req_item_type)
//  rsp_      out        rsp_valid/rsp_stall rsp_data (rsp_item_type)
//  csr_      in         csr_valid/csr_ready csr_index, csr_data
//
// each item passes five steps: accept, window restart, purge, search, apply;
// the sequencer handles one item at a time through these steps.
// apply waits while the result register still holds an untaken result.
// synchronous active-high reset empties the table and clears the window.
// configuration writes are taken every cycle.
module stream_slot_admission_limiter import ssal_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

`include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   ssal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot table and result register
   ssal_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // checks
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPLIES(a_delay_only_ok, clock, reset, rsp_valid && rsp_data.status != STATUS_OK, rsp_data.wait_ms == 22'd0)
   `ASSERT_IMPLIES(a_load_only_idle, clock, reset, cmd.load, !req_stall && !cmd.apply)

endmodule
